// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/pci3_pkg.sv
// ----------------------------------------------------------------------------
// pci3_pkg
// Types, widths and elaboration-time helpers for the 3-D Peano curve index.
// ----------------------------------------------------------------------------
package pci3_pkg;

  localparam int unsigned COORD_W    = 21;
  localparam int unsigned INDEX_W    = 62;
  localparam int unsigned DIGIT_W    = 2;
  localparam int unsigned GROUP_W    = 5;
  localparam int unsigned MAX_DIGITS = 13;

  // Data carried from cell to cell: the coordinate remainders still to be
  // split, the parity of the digits consumed so far, the partial index and
  // the range flag.
  typedef struct packed {
    logic [COORD_W-1:0] rem_x;
    logic [COORD_W-1:0] rem_y;
    logic [COORD_W-1:0] rem_z;
    logic               par_x;
    logic               par_y;
    logic               par_z;
    logic [INDEX_W-1:0] idx;
    logic               err;
  } lane_t;

  // 3^n, used at elaboration only.
  function automatic logic [63:0] pow3(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd3;
    end
    return p;
  endfunction

  // Leading base-3 digit of v, given the weight p of that digit.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [COORD_W-1:0] v,
                                                  input logic [COORD_W-1:0] p);
    logic [DIGIT_W-1:0] d;
    if ({1'b0, v} >= {p, 1'b0}) begin
      d = 2'd2;
    end else if (v >= p) begin
      d = 2'd1;
    end else begin
      d = 2'd0;
    end
    return d;
  endfunction

  // d or its reflection 2-d.
  function automatic logic [DIGIT_W-1:0] reflect(input logic [DIGIT_W-1:0] d,
                                                 input logic flip);
    return flip ? DIGIT_W'(2'd2 - d) : d;
  endfunction

endpackage

// File: hw/rtl/pci3_cell.sv
// ----------------------------------------------------------------------------
// pci3_cell
// One level of the curve: splits off one base-3 digit per coordinate,
// reflects it and adds the digit group into the index, then registers.
// ----------------------------------------------------------------------------
module pci3_cell #(
  parameter int unsigned DIGITS = 13,
  parameter int unsigned LEVEL  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pci3_pkg::lane_t lane_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pci3_pkg::lane_t lane_o
);

  localparam int unsigned SHIFT = DIGITS - 1 - LEVEL;
  localparam logic [pci3_pkg::COORD_W-1:0] DigitWeight =
    pci3_pkg::COORD_W'(pci3_pkg::pow3(SHIFT));
  localparam logic [pci3_pkg::INDEX_W-1:0] GroupWeight =
    pci3_pkg::INDEX_W'(pci3_pkg::pow3(3 * SHIFT));

  logic                             valid_q;
  pci3_pkg::lane_t                  lane_q, lane_d;
  logic [pci3_pkg::DIGIT_W-1:0]     dx, dy, dz, rx, ry, rz;
  logic                             bx, by, bz;
  logic [pci3_pkg::GROUP_W-1:0]     group;
  logic [pci3_pkg::INDEX_W-1:0]     term;

  always_comb begin
    dx = pci3_pkg::digit_of(lane_i.rem_x, DigitWeight);
    dy = pci3_pkg::digit_of(lane_i.rem_y, DigitWeight);
    dz = pci3_pkg::digit_of(lane_i.rem_z, DigitWeight);
    // Odd digits are the ones equal to 1.
    bx = (dx == 2'd1);
    by = (dy == 2'd1);
    bz = (dz == 2'd1);
    rx = pci3_pkg::reflect(dx, lane_i.par_y ^ lane_i.par_z);
    ry = pci3_pkg::reflect(dy, lane_i.par_x ^ bx ^ lane_i.par_z);
    rz = pci3_pkg::reflect(dz, lane_i.par_x ^ bx ^ lane_i.par_y ^ by);
    group = pci3_pkg::GROUP_W'(rx) * 5'd9 + pci3_pkg::GROUP_W'(ry) * 5'd3
          + pci3_pkg::GROUP_W'(rz);
    // group times a constant weight, as a sum of shifted copies.
    term = '0;
    for (int unsigned b = 0; b < pci3_pkg::GROUP_W; b++) begin
      if (group[b]) begin
        term = term + (GroupWeight << b);
      end
    end

    lane_d       = lane_i;
    lane_d.rem_x = lane_i.rem_x - pci3_pkg::COORD_W'(dx) * DigitWeight;
    lane_d.rem_y = lane_i.rem_y - pci3_pkg::COORD_W'(dy) * DigitWeight;
    lane_d.rem_z = lane_i.rem_z - pci3_pkg::COORD_W'(dz) * DigitWeight;
    lane_d.par_x = lane_i.par_x ^ bx;
    lane_d.par_y = lane_i.par_y ^ by;
    lane_d.par_z = lane_i.par_z ^ bz;
    lane_d.idx   = lane_i.idx + term;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

// File: hw/rtl/peano_curve_index_3d.sv
// ----------------------------------------------------------------------------
// peano_curve_index_3d
// Position of a 3-D point along a Peano space-filling curve.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                | Beat payload
//   --------+--------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o  | coord_x_i, coord_y_i, coord_z_i
//   out     | out_valid_o / out_ready_i| curve_index_o, range_error_o
//
// An accepted input beat passes through the row of DIGITS cells, one per
// base-3 level, each a register stage. One beat is accepted per cycle while
// no stall from the output has backed up the row to the input.
// Reset clears only the valid bit of every cell; the block needs no warm-up.
// Each cell stalls on its own: it holds its beat while the next one is full
// and blocked, so empty cells keep filling while a result waits at the output.
//
// The coordinates are checked against 3^DIGITS before the first cell. Each
// cell then takes the leading digit of each remainder by two compares against
// its level's weight, reflects it (d becomes 2-d) when the parity of the
// other coordinates' digits ranking above it is odd, and adds the base-27
// group x*9 + y*3 + z times 27^(level weight) into the running index. Digit
// parities travel down the row along with the remainders. A coordinate out of
// range sets range_error and forces the index to zero at the output.
module peano_curve_index_3d #(
  parameter int unsigned DIGITS = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pci3_pkg::COORD_W-1:0]   coord_x_i,
  input  logic [pci3_pkg::COORD_W-1:0]   coord_y_i,
  input  logic [pci3_pkg::COORD_W-1:0]   coord_z_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pci3_pkg::INDEX_W-1:0]   curve_index_o,
  output logic                           range_error_o
);

  localparam logic [pci3_pkg::COORD_W:0] Limit =
    (pci3_pkg::COORD_W + 1)'(pci3_pkg::pow3(DIGITS));

  logic            valid [DIGITS+1];
  logic            ready [DIGITS+1];
  pci3_pkg::lane_t lane  [DIGITS+1];

  // Entry of the row: full coordinates, no digits consumed yet.
  always_comb begin
    lane[0]       = '0;
    lane[0].rem_x = coord_x_i;
    lane[0].rem_y = coord_y_i;
    lane[0].rem_z = coord_z_i;
    lane[0].err   = ({1'b0, coord_x_i} >= Limit) || ({1'b0, coord_y_i} >= Limit)
                 || ({1'b0, coord_z_i} >= Limit);
  end

  assign valid[0]   = in_valid_i;
  assign in_ready_o = ready[0];

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    pci3_cell #(
      .DIGITS (DIGITS),
      .LEVEL  (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .lane_i  (lane[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .lane_o  (lane[k+1])
    );
  end

  assign ready[DIGITS]  = out_ready_i;
  assign out_valid_o    = valid[DIGITS];
  assign range_error_o  = lane[DIGITS].err;
  assign curve_index_o  = lane[DIGITS].err ? '0 : lane[DIGITS].idx;

endmodule

// File: hw/rtl/pci3_checker.sv
// ----------------------------------------------------------------------------
// pci3_checker
// Port-level checks for the Peano curve index block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pci3_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [pci3_pkg::INDEX_W-1:0] curve_index_o,
  input logic                         range_error_o
);

  // An out-of-range beat always carries a zero index.
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && range_error_o, curve_index_o == '0)

  // With the output stage empty, every cell can take a beat.
  `ASSERT_IMPL(a_empty_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // A stalled output beat stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // A stalled output beat keeps its payload.
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
               $stable(curve_index_o) && $stable(range_error_o))

endmodule

bind peano_curve_index_3d pci3_checker u_pci3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .curve_index_o (curve_index_o),
  .range_error_o (range_error_o)
);
